@@ src/usbreq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usbreq_pkg
// Shared constants for the USB setup request handler: interface count,
// request codes, descriptor types, reply kinds and device states.
// ----------------------------------------------------------------------------
package usbreq_pkg;

  // Interface table
  localparam int NUM_INTERFACES = 4;
  localparam int IFC_IDX_W      = (NUM_INTERFACES > 1) ? $clog2(NUM_INTERFACES) : 1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_OS_VENDOR_CODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SERIAL_VALID   = 1'd1;
  localparam logic [7:0]           OS_VENDOR_CODE_RST = 8'h01;

  // bmRequestType type field
  localparam logic [1:0] RT_STANDARD = 2'd0;
  localparam logic [1:0] RT_VENDOR   = 2'd2;

  // Standard request codes
  localparam logic [7:0] REQ_GET_STATUS        = 8'd0;
  localparam logic [7:0] REQ_SET_ADDRESS       = 8'd5;
  localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
  localparam logic [7:0] REQ_GET_CONFIGURATION = 8'd8;
  localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;
  localparam logic [7:0] REQ_GET_INTERFACE     = 8'd10;
  localparam logic [7:0] REQ_SET_INTERFACE     = 8'd11;

  // Descriptor types and special indexes
  localparam logic [7:0] DT_DEVICE   = 8'd1;
  localparam logic [7:0] DT_CONFIG   = 8'd2;
  localparam logic [7:0] DT_STRING   = 8'd3;
  localparam logic [7:0] STR_SERIAL  = 8'd3;
  localparam logic [7:0] STR_OS      = 8'hee;
  localparam logic [4:0] RCPT_MAX    = 5'd2;
  localparam logic [15:0] OS_IDX_COMPAT = 16'h0004;
  localparam logic [15:0] OS_IDX_PROPS  = 16'h0005;

  // Reply kinds
  localparam logic [3:0] K_NONE     = 4'd0;
  localparam logic [3:0] K_DEVICE   = 4'd1;
  localparam logic [3:0] K_CONFIG   = 4'd2;
  localparam logic [3:0] K_STR0     = 4'd3;
  localparam logic [3:0] K_STR3     = 4'd6;
  localparam logic [3:0] K_CHIP_SN  = 4'd7;
  localparam logic [3:0] K_OS_STR   = 4'd8;
  localparam logic [3:0] K_COMPAT   = 4'd9;
  localparam logic [3:0] K_PROPS    = 4'd10;
  localparam logic [3:0] K_RAM_BYTE = 4'd11;
  localparam logic [3:0] K_STATUS   = 4'd12;

  // Device states
  localparam logic [1:0] DS_DEFAULT    = 2'd0;
  localparam logic [1:0] DS_ADDR_PEND  = 2'd1;
  localparam logic [1:0] DS_ADDRESSED  = 2'd2;
  localparam logic [1:0] DS_CONFIGURED = 2'd3;

  // Reply lengths
  localparam logic [1:0] LEN_NONE   = 2'd0;
  localparam logic [1:0] LEN_BYTE   = 2'd1;
  localparam logic [1:0] LEN_STATUS = 2'd2;

  // One result item
  typedef struct packed {
    logic [1:0] device_state_out;
    logic       endpoints_init;
    logic       endpoints_reset;
    logic [6:0] new_address;
    logic       address_load;
    logic [1:0] reply_length;
    logic [7:0] reply_byte;
    logic       accepted;
  } result_t;

endpackage

@@ src/usb_setup_request_handler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_setup_request_handler
// Decodes one USB setup packet per item, keeps device state, active
// configuration and the alternate setting table, and returns one result.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  s_axis    in   s_tvalid / s_tready    s_tdata: type, code, value, index
//  m_axis    out  m_tvalid / m_tready    m_tdata: result fields, m_tuser: kind
//  cfg       in   cfg_we                 cfg_index, cfg_wdata
//
//  One item per cycle while the output is not stalled; a result appears in the
//  cycle after its item is taken. The decode and state update sit between the
//  input handshake and a single result register; the state registers update on
//  the accepting edge. s_tready stays high while the result register is empty or being taken.
//  rst (synchronous) clears device state, configuration, alternate settings,
//  serial_valid and the result valid flag, and sets os_vendor_code to its reset value.
// ----------------------------------------------------------------------------
module usb_setup_request_handler (
  input  logic                             clk,
  input  logic                             rst,
  // request_type[7:0], request_code[15:8], request_value[31:16],
  // request_index[47:32]
  input  logic [47:0]                      s_tdata,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // accepted[0], reply_byte[8:1], reply_length[10:9], address_load[11],
  // new_address[18:12], endpoints_reset[19], endpoints_init[20],
  // device_state_out[22:21], zero[23]
  output logic [23:0]                      m_tdata,
  // reply_kind[3:0]
  output logic [3:0]                       m_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic                             cfg_we,
  input  logic [usbreq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                       cfg_wdata
);
  import usbreq_pkg::*;

  // Config registers
  logic [7:0] os_vendor_code;
  logic       serial_valid;

  // Device state
  logic [1:0] device_state;
  logic [1:0] device_state_next;
  logic [7:0] active_config;
  logic [7:0] active_config_next;
  logic [7:0] alt_settings      [NUM_INTERFACES];
  logic [7:0] alt_settings_next [NUM_INTERFACES];

  // Result register
  result_t    result;
  result_t    result_next;
  logic [3:0] result_kind;
  logic [3:0] result_kind_next;
  logic       out_valid;

  // Field view of the input item
  logic [7:0]  request_type;
  logic [7:0]  request_code;
  logic [15:0] request_value;
  logic [15:0] request_index;
  logic        to_host;
  logic [1:0]  rtype_kind;
  logic        ifc_in_range;
  logic [IFC_IDX_W-1:0] ifc_sel;
  logic        in_fire;

  assign request_type  = s_tdata[7:0];
  assign request_code  = s_tdata[15:8];
  assign request_value = s_tdata[31:16];
  assign request_index = s_tdata[47:32];
  assign to_host       = request_type[7];
  assign rtype_kind    = request_type[6:5];
  assign ifc_in_range  = request_index < 16'(NUM_INTERFACES);
  assign ifc_sel       = request_index[IFC_IDX_W-1:0];

  assign s_tready = !out_valid || m_tready;
  assign in_fire  = s_tvalid && s_tready;

  // Decode the request and work out the next state
  always_comb begin
    device_state_next  = device_state;
    active_config_next = active_config;
    for (int i = 0; i < NUM_INTERFACES; i++) begin
      alt_settings_next[i] = alt_settings[i];
    end
    result_next      = '0;
    result_kind_next = K_NONE;

    if (rtype_kind == RT_STANDARD) begin
      unique case (request_code)
        REQ_SET_ADDRESS: begin
          result_next.accepted     = 1'b1;
          result_next.address_load = 1'b1;
          result_next.new_address  = request_value[6:0];
          device_state_next        = DS_ADDR_PEND;
        end
        REQ_GET_DESCRIPTOR: begin
          if (to_host) begin
            unique case (request_value[15:8])
              DT_DEVICE: begin
                result_next.accepted = 1'b1;
                result_kind_next     = K_DEVICE;
              end
              DT_CONFIG: begin
                result_next.accepted = 1'b1;
                result_kind_next     = K_CONFIG;
              end
              DT_STRING: begin
                if (request_value[7:0] < STR_SERIAL) begin
                  result_next.accepted = 1'b1;
                  result_kind_next     = K_STR0 + request_value[3:0];
                end else if (request_value[7:0] == STR_SERIAL) begin
                  result_next.accepted = 1'b1;
                  result_kind_next     = serial_valid ? K_STR3 : K_CHIP_SN;
                end else if (request_value[7:0] == STR_OS) begin
                  result_next.accepted = 1'b1;
                  result_kind_next     = K_OS_STR;
                end
              end
              default: ;
            endcase
          end
        end
        REQ_SET_CONFIGURATION: begin
          result_next.accepted        = 1'b1;
          result_next.endpoints_reset = 1'b1;
          for (int i = 0; i < NUM_INTERFACES; i++) begin
            alt_settings_next[i] = '0;
          end
          active_config_next = request_value[7:0];
          if (request_value[7:0] == 8'd0) begin
            device_state_next = DS_ADDRESSED;
          end else begin
            device_state_next          = DS_CONFIGURED;
            result_next.endpoints_init = 1'b1;
          end
        end
        REQ_GET_CONFIGURATION: begin
          result_next.accepted     = 1'b1;
          result_kind_next         = K_RAM_BYTE;
          result_next.reply_byte   = active_config;
          result_next.reply_length = LEN_BYTE;
        end
        REQ_GET_STATUS: begin
          if (request_type[4:0] <= RCPT_MAX) begin
            result_next.accepted     = 1'b1;
            result_kind_next         = K_STATUS;
            result_next.reply_length = LEN_STATUS;
          end
        end
        REQ_GET_INTERFACE: begin
          if (ifc_in_range) begin
            result_next.accepted     = 1'b1;
            result_kind_next         = K_RAM_BYTE;
            result_next.reply_length = LEN_BYTE;
            result_next.reply_byte   = alt_settings[ifc_sel];
          end
        end
        REQ_SET_INTERFACE: begin
          if (ifc_in_range) begin
            result_next.accepted       = 1'b1;
            alt_settings_next[ifc_sel] = request_value[7:0];
          end
        end
        default: ;
      endcase
    end else if (rtype_kind == RT_VENDOR) begin
      if (request_code == os_vendor_code && to_host) begin
        if (request_index == OS_IDX_COMPAT) begin
          result_next.accepted = 1'b1;
          result_kind_next     = K_COMPAT;
        end else if (request_index == OS_IDX_PROPS) begin
          result_next.accepted = 1'b1;
          result_kind_next     = K_PROPS;
        end
      end
    end

    result_next.device_state_out = device_state_next;
  end

  // Write config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      os_vendor_code <= OS_VENDOR_CODE_RST;
      serial_valid   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OS_VENDOR_CODE: os_vendor_code <= cfg_wdata;
        CFG_SERIAL_VALID:   serial_valid   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Advance device state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      device_state  <= DS_DEFAULT;
      active_config <= '0;
      for (int i = 0; i < NUM_INTERFACES; i++) begin
        alt_settings[i] <= '0;
      end
    end else if (in_fire) begin
      device_state  <= device_state_next;
      active_config <= active_config_next;
      for (int i = 0; i < NUM_INTERFACES; i++) begin
        alt_settings[i] <= alt_settings_next[i];
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      result      <= result_next;
      result_kind <= result_kind_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, result};
  assign m_tuser  = result_kind;

`ifndef SYNTHESIS
  // Endpoint init only comes with endpoint reset
  a_init_with_reset: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.endpoints_init |-> result.endpoints_reset)
    else $error("endpoints_init without endpoints_reset");

  // Reply length follows the reply kind
  a_len_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((result.reply_length != LEN_NONE) ==
                   (result_kind == K_RAM_BYTE || result_kind == K_STATUS)))
    else $error("reply_length does not match reply_kind");

  // Set address moves the device to address pending
  a_set_addr_state: assert property (@(posedge clk) disable iff (rst)
    in_fire && rtype_kind == RT_STANDARD && request_code == REQ_SET_ADDRESS
    |=> device_state == DS_ADDR_PEND && result.address_load)
    else $error("set address did not update state");

  // Reported state matches the stored state after each item
  a_state_out: assert property (@(posedge clk) disable iff (rst)
    $past(in_fire) |-> result.device_state_out == device_state)
    else $error("device_state_out out of step with device_state");
`endif

endmodule
